[src/bsa_pkg.sv]
// Shared types, constants and fixed-point helpers of the Bellman argmax block.
package bsa_pkg;

   localparam int IN_LANES  = 4;
   localparam int CSR_IDX_W = 2;

   typedef enum logic [1:0] {
      CMD_LOAD_WEIGHT = 2'd0,
      CMD_LOAD_CONT   = 2'd1,
      CMD_LOAD_GRID   = 2'd2,
      CMD_EVAL        = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_POSITIONS = 2'd0,
      REG_DIMS      = 2'd1
   } reg_idx_type;

   typedef struct packed {
      logic init;     // load accumulator with reward
      logic mul_en;   // capture a product
      logic dot_sel;  // product is s * grid rather than weight * cont
      logic acc_en;   // add the held product into the accumulator
   } lane_ctrl_type;

   typedef struct packed {
      logic sum_en;   // add one lane term into the value
      logic first;    // first lane: start from zero
      logic commit;   // compare against running best
      logic emit;     // deliver the best as a result item
   } merge_ctrl_type;

   function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
      logic signed [32:0] s;
      s = {a[31], a} + {b[31], b};
      if (s[32] != s[31]) sat_add = s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      else sat_add = s[31:0];
   endfunction

   // Product already formed: floor shift by 16 then saturate.
   function automatic logic signed [31:0] q_sat(input logic signed [63:0] p);
      logic signed [63:0] t;
      t = p >>> 16;
      if (t > 64'sh0000_0000_7fff_ffff) q_sat = 32'sh7fff_ffff;
      else if (t < -64'sh0000_0000_8000_0000) q_sat = 32'sh8000_0000;
      else q_sat = t[31:0];
   endfunction

endpackage

[src/bsa_if.sv]
// Channel interfaces: request items, result items and register writes.
interface bsa_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         cmd;
   logic [2:0]         cur_pos;
   logic [2:0]         act;
   logic [2:0]         next_pos;
   logic signed [31:0] weight;
   logic signed [31:0] vec_0;
   logic signed [31:0] vec_1;
   logic signed [31:0] vec_2;
   logic signed [31:0] vec_3;
   logic               last;
   modport source (output valid, cmd, cur_pos, act, next_pos, weight,
                   vec_0, vec_1, vec_2, vec_3, last, input ready);
   modport sink (input valid, cmd, cur_pos, act, next_pos, weight,
                 vec_0, vec_1, vec_2, vec_3, last, output ready);
endinterface

interface bsa_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         best_action;
   logic signed [31:0] best_value;
   logic signed [31:0] subgrad_0;
   logic signed [31:0] subgrad_1;
   logic signed [31:0] subgrad_2;
   logic signed [31:0] subgrad_3;
   modport source (output valid, best_action, best_value, subgrad_0, subgrad_1,
                   subgrad_2, subgrad_3, input ready);
   modport sink (input valid, best_action, best_value, subgrad_0, subgrad_1,
                 subgrad_2, subgrad_3, output ready);
endinterface

interface bsa_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[src/bsa_lane.sv]
// One subgradient lane: shared multiplier, saturating accumulator.
module bsa_lane
   import bsa_pkg::*;
(
   input  logic               clock,
   input  lane_ctrl_type      ctrl,
   input  logic               lane_en,
   input  logic signed [31:0] reward,
   input  logic signed [31:0] weight,
   input  logic signed [31:0] cont,
   input  logic signed [31:0] grid,
   output logic signed [31:0] subgrad,
   output logic signed [31:0] term
);
   logic signed [63:0] prod_ff, prod_in;
   logic signed [31:0] acc_ff, acc_in;
   logic signed [31:0] op_a, op_b;

   assign op_a = ctrl.dot_sel ? acc_ff : weight;
   assign op_b = ctrl.dot_sel ? grid : cont;

   always_comb begin
      prod_in = ctrl.mul_en ? (64'(op_a) * 64'(op_b)) : prod_ff;
      acc_in  = acc_ff;
      if (ctrl.init) begin
         acc_in = lane_en ? reward : 32'sd0;
      end else if (ctrl.acc_en && lane_en) begin
         acc_in = sat_add(acc_ff, q_sat(prod_ff));
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign subgrad = acc_ff;
   assign term    = q_sat(prod_ff);
endmodule

[src/bsa_merge.sv]
// Lane merge: ordered dot-product sum, first-max tracking, result register.
module bsa_merge
   import bsa_pkg::*;
#(
   parameter int LANES = 4,
   parameter int KW    = 2
)(
   input  logic               clock,
   input  logic               reset,
   input  merge_ctrl_type     ctrl,
   input  logic [KW-1:0]      lane_sel,
   input  logic signed [31:0] terms [LANES],
   input  logic signed [31:0] subgrads [LANES],
   input  logic [2:0]         action,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic [2:0]         rsp_action,
   output logic signed [31:0] rsp_value,
   output logic signed [31:0] rsp_sub [IN_LANES]
);
   logic signed [31:0] val_ff, val_in;
   logic signed [31:0] best_val_ff, best_val_in;
   logic [2:0]         best_act_ff, best_act_in;
   logic signed [31:0] best_sub_ff [LANES];
   logic signed [31:0] best_sub_in [LANES];
   logic               have_ff, have_in;
   logic               out_valid_ff, out_valid_in;
   logic               take;

   assign take = ctrl.commit && (!have_ff || (val_ff > best_val_ff));

   always_comb begin
      val_in       = val_ff;
      best_val_in  = best_val_ff;
      best_act_in  = best_act_ff;
      best_sub_in  = best_sub_ff;
      have_in      = have_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      if (ctrl.sum_en) begin
         val_in = sat_add(ctrl.first ? 32'sd0 : val_ff, terms[lane_sel]);
      end
      if (take) begin
         have_in     = 1'b1;
         best_val_in = val_ff;
         best_act_in = action;
         best_sub_in = subgrads;
      end
      if (ctrl.commit && ctrl.emit) begin
         have_in      = 1'b0;
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         best_val_ff  <= '0;
         best_act_ff  <= '0;
         for (int l = 0; l < LANES; l++) best_sub_ff[l] <= '0;
      end else begin
         have_ff      <= have_in;
         out_valid_ff <= out_valid_in;
         best_val_ff  <= best_val_in;
         best_act_ff  <= best_act_in;
         best_sub_ff  <= best_sub_in;
      end
      val_ff <= val_in;
      if (ctrl.commit && ctrl.emit) begin
         rsp_action <= best_act_in;
         rsp_value  <= best_val_in;
         for (int l = 0; l < IN_LANES; l++) begin
            rsp_sub[l] <= (l < LANES) ? best_sub_in[l % LANES] : 32'sd0;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
endmodule

[src/bellman_subgradient_argmax_top.sv]
// Top level of the Bellman backup block with argmax over actions.
//
// Channels: req_chan takes load and evaluate items, rsp_chan gives one
// result item per evaluate item marked last, csr_chan writes the two
// registers (always ready, write only while the block is idle).
// Load items are taken back to back: ready stays high in idle.
// Evaluate: one item in flight. With npos the clamped positions_in_use,
// ready stays low from the accepting edge until the return to idle. Weight
// and continuation reads issue one position a cycle for npos positions,
// then each lane multiplies and accumulates through a two-stage pipe; the
// dot product takes a multiply step plus one merge step per lane, in lane
// order, then a compare step. Result appears the cycle after the compare
// of the last action.
// Reset clears the registers to defaults and the running best; the weight,
// continuation and grid stores hold garbage until loaded.
// A stalled receiver holds the result register. Loads and non-final
// evaluates still go through, but an evaluate that must emit waits in the
// compare step until the slot frees, and the input stays stalled meanwhile.
module bellman_subgradient_argmax_top
   import bsa_pkg::*;
#(
   parameter int MAX_POSITIONS = 8,
   parameter int MAX_ACTIONS   = 8,
   parameter int LANES         = 4
)(
   input  logic      clock,
   input  logic      reset,
   bsa_req_if.sink   req_chan,
   bsa_rsp_if.source rsp_chan,
   bsa_csr_if.sink   csr_chan
);
   localparam int WT_DEPTH = MAX_POSITIONS * MAX_ACTIONS * MAX_POSITIONS;
   localparam int AW = (WT_DEPTH > 1) ? $clog2(WT_DEPTH) : 1;
   localparam int PW = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
   localparam int NW = $clog2(MAX_POSITIONS + 1);
   localparam int KW = (LANES > 1) ? $clog2(LANES) : 1;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_SUM  = 5'b00010,
      S_DOT  = 5'b00100,
      S_DSUM = 5'b01000,
      S_CMP  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // registers
   logic [3:0] pos_ff;
   logic [2:0] dims_ff;
   logic [NW-1:0] npos;

   // item context
   logic [AW-1:0] base_ff, base_in;
   logic          idx_ok_ff, idx_ok_in;
   logic [2:0]    act_ff, act_in;
   logic          last_ff, last_in;
   logic [NW-1:0] j_ff, j_in;
   logic [KW-1:0] k_ff, k_in;
   logic          rd_v_ff, mul_v_ff;
   logic          rd_v;

   // stores
   logic signed [31:0]        wt_mem [WT_DEPTH];
   logic [LANES*32-1:0]       cont_mem [MAX_POSITIONS];
   logic signed [31:0]        wt_rd_ff;
   logic [LANES*32-1:0]       cont_rd_ff;
   logic signed [31:0]        grid_ff [LANES];

   logic signed [31:0] req_vec [LANES];
   logic signed [31:0] terms [LANES];
   logic signed [31:0] subs [LANES];
   logic signed [31:0] rsp_sub [IN_LANES];
   logic               req_fire, eval_fire, rsp_valid;
   logic               w_ok, np_ok, cp_ok, ac_ok;
   logic [31:0]        wr_addr_w, base_w;
   lane_ctrl_type      lctrl;
   merge_ctrl_type     mctrl;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign csr_chan.ready = 1'b1;
   assign req_fire  = req_chan.valid && req_chan.ready;
   assign eval_fire = req_fire && (cmd_type'(req_chan.cmd) == CMD_EVAL);

   always_comb begin
      for (int l = 0; l < LANES; l++) req_vec[l] = 32'sd0;
      req_vec[0] = req_chan.vec_0;
      if (LANES > 1) req_vec[1 % LANES] = req_chan.vec_1;
      if (LANES > 2) req_vec[2 % LANES] = req_chan.vec_2;
      if (LANES > 3) req_vec[3 % LANES] = req_chan.vec_3;
   end

   assign cp_ok = 32'(req_chan.cur_pos) < MAX_POSITIONS;
   assign ac_ok = 32'(req_chan.act) < MAX_ACTIONS;
   assign np_ok = 32'(req_chan.next_pos) < MAX_POSITIONS;
   assign w_ok  = cp_ok && ac_ok && np_ok;
   assign base_w = (32'(req_chan.cur_pos) * MAX_ACTIONS + 32'(req_chan.act))
                   * MAX_POSITIONS;
   assign wr_addr_w = base_w + 32'(req_chan.next_pos);

   assign npos = (32'(pos_ff) > MAX_POSITIONS) ? NW'(MAX_POSITIONS) : NW'(pos_ff);

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= 4'd8;
         dims_ff <= 3'd4;
      end else if (csr_chan.valid && csr_chan.ready) begin
         case (reg_idx_type'(csr_chan.index))
            REG_POSITIONS: pos_ff  <= csr_chan.data[3:0];
            REG_DIMS:      dims_ff <= csr_chan.data[2:0];
            default: ;
         endcase
      end
   end

   // stores: written on load items, read one position a cycle
   always_ff @(posedge clock) begin
      if (req_fire && (cmd_type'(req_chan.cmd) == CMD_LOAD_WEIGHT) && w_ok) begin
         wt_mem[wr_addr_w[AW-1:0]] <= req_chan.weight;
      end
      if (req_fire && (cmd_type'(req_chan.cmd) == CMD_LOAD_CONT) && np_ok) begin
         for (int l = 0; l < LANES; l++) begin
            cont_mem[PW'(req_chan.next_pos)][l*32 +: 32] <= req_vec[l];
         end
      end
      if (req_fire && (cmd_type'(req_chan.cmd) == CMD_LOAD_GRID)) begin
         grid_ff <= req_vec;
      end
      wt_rd_ff   <= wt_mem[base_ff + AW'(j_ff)];
      cont_rd_ff <= cont_mem[j_ff[PW-1:0]];
   end

   // sequencer
   assign rd_v = (state_ff == S_SUM) && (j_ff < npos);

   always_comb begin
      state_in  = state_ff;
      base_in   = base_ff;
      idx_ok_in = idx_ok_ff;
      act_in    = act_ff;
      last_in   = last_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      lctrl     = '0;
      mctrl     = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (eval_fire) begin
               state_in   = S_SUM;
               base_in    = base_w[AW-1:0];
               idx_ok_in  = cp_ok && ac_ok;
               act_in     = req_chan.act;
               last_in    = req_chan.last;
               j_in       = '0;
               lctrl.init = 1'b1;
            end
         end
         S_SUM: begin
            lctrl.mul_en = rd_v_ff;
            lctrl.acc_en = mul_v_ff;
            if (rd_v) j_in = j_ff + NW'(1);
            if (!rd_v && !rd_v_ff && !mul_v_ff) state_in = S_DOT;
         end
         S_DOT: begin
            lctrl.mul_en  = 1'b1;
            lctrl.dot_sel = 1'b1;
            k_in          = '0;
            state_in      = S_DSUM;
         end
         S_DSUM: begin
            mctrl.sum_en = 1'b1;
            mctrl.first  = (k_ff == '0);
            k_in         = k_ff + KW'(1);
            if (32'(k_ff) == LANES - 1) state_in = S_CMP;
         end
         S_CMP: begin
            // a final item waits here while the result slot is still full
            if (!(last_ff && rsp_valid)) begin
               mctrl.commit = 1'b1;
               mctrl.emit   = last_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rd_v_ff  <= 1'b0;
         mul_v_ff <= 1'b0;
         j_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         rd_v_ff  <= rd_v;
         mul_v_ff <= rd_v_ff;
         j_ff     <= j_in;
         k_ff     <= k_in;
      end
      base_ff   <= base_in;
      idx_ok_ff <= idx_ok_in;
      act_ff    <= act_in;
      last_ff   <= last_in;
   end

   // lanes
   for (genvar l = 0; l < LANES; l++) begin : g_lane
      bsa_lane u_lane (
         .clock   (clock),
         .ctrl    (lctrl),
         .lane_en (32'(l) < 32'(dims_ff)),
         .reward  (req_vec[l]),
         .weight  (idx_ok_ff ? wt_rd_ff : 32'sd0),
         .cont    (cont_rd_ff[l*32 +: 32]),
         .grid    (grid_ff[l]),
         .subgrad (subs[l]),
         .term    (terms[l])
      );
   end

   bsa_merge #(.LANES(LANES), .KW(KW)) u_merge (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (mctrl),
      .lane_sel   (k_ff),
      .terms      (terms),
      .subgrads   (subs),
      .action     (act_ff),
      .rsp_ready  (rsp_chan.ready),
      .rsp_valid  (rsp_valid),
      .rsp_action (rsp_chan.best_action),
      .rsp_value  (rsp_chan.best_value),
      .rsp_sub    (rsp_sub)
   );

   assign rsp_chan.valid     = rsp_valid;
   assign rsp_chan.subgrad_0 = rsp_sub[0];
   assign rsp_chan.subgrad_1 = rsp_sub[1];
   assign rsp_chan.subgrad_2 = rsp_sub[2];
   assign rsp_chan.subgrad_3 = rsp_sub[3];

   // a new result only comes out of a compare step
   a_rsp_from_cmp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == S_CMP))
      else $error("result raised outside compare step");

   // read issue never runs past the positions in use
   a_j_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SUM) |-> (j_ff <= npos))
      else $error("position counter overran");

   // products only follow a read
   a_mul_after_rd: assert property (@(posedge clock) disable iff (reset)
      mul_v_ff |-> $past(rd_v_ff))
      else $error("product stage without read");
endmodule
